// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/pgcs_pkg.sv
package pgcs_pkg;

  // Field and datapath widths.
  localparam int CELL_W  = 6;
  localparam int NUM_W   = 33;
  localparam int DEN_W   = 6;
  localparam int PADDR_W = 4;

  // Command queue between the front and back parts.
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = 1;
  localparam int CQ_CNT_W = 2;

  // Result queue in the back part.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  // Register indexes on the APB port.
  localparam logic [1:0] REG_SOURCE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_SOURCE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CELLS_PER_ROW   = 2'd2;
  localparam logic [1:0] REG_OUTPUT_CAPACITY = 2'd3;

  localparam logic [15:0]       RST_SOURCE_WIDTH    = 16'd1;
  localparam logic [15:0]       RST_SOURCE_HEIGHT   = 16'd0;
  localparam logic [CELL_W-1:0] RST_CELLS_PER_ROW   = 6'd62;
  localparam logic [15:0]       RST_OUTPUT_CAPACITY = 16'hFFFF;

  localparam logic [6:0] CODE_NEWLINE = 7'd10;
  localparam logic [6:0] CODE_NUL     = 7'd0;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RENDER  = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    op_t        kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0]       source_width;
    logic [15:0]       source_height;
    logic [CELL_W-1:0] cells_per_row;
    logic [15:0]       output_capacity;
  } cfg_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
    logic       image_done;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_DECIDE,
    ST_SY_DIV,
    ST_BASE,
    ST_XDIV,
    ST_CHARS,
    ST_ROW_END,
    ST_POST_PROD,
    ST_POST_CHK,
    ST_NUL
  } seq_state_t;

  // Gray level g maps to ramp entry g*9/15 of " .:-=+*#%@".
  function automatic logic [6:0] gray_glyph(input logic [3:0] g);
    logic [6:0] code;
    case (g) inside
      4'd0, 4'd1:   code = 7'd32;
      4'd2, 4'd3:   code = 7'd46;
      4'd4:         code = 7'd58;
      4'd5, 4'd6:   code = 7'd45;
      4'd7, 4'd8:   code = 7'd61;
      4'd9:         code = 7'd43;
      4'd10, 4'd11: code = 7'd42;
      4'd12, 4'd13: code = 7'd35;
      4'd14:        code = 7'd37;
      4'd15:        code = 7'd64;
      default:      code = 7'd32;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/pgcs_if.sv
interface pgcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] packed_byte;

  modport source (output valid, output operation, output packed_byte, input ready);
  modport sink (input valid, input operation, input packed_byte, output ready);
endinterface

interface pgcs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;
  logic       image_done;

  modport source (output valid, output char_code, output last, output image_done,
                  input ready);
  modport sink (input valid, input char_code, input last, input image_done,
                output ready);
endinterface

// File: rtl/pgcs_cfg.sv
module pgcs_cfg
  import pgcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width    <= RST_SOURCE_WIDTH;
      cfg_r.source_height   <= RST_SOURCE_HEIGHT;
      cfg_r.cells_per_row   <= RST_CELLS_PER_ROW;
      cfg_r.output_capacity <= RST_OUTPUT_CAPACITY;
    end else if (wr_en) begin
      case (idx)
        REG_SOURCE_WIDTH:    cfg_r.source_width    <= pwdata[15:0];
        REG_SOURCE_HEIGHT:   cfg_r.source_height   <= pwdata[15:0];
        REG_CELLS_PER_ROW:   cfg_r.cells_per_row   <= pwdata[CELL_W-1:0];
        REG_OUTPUT_CAPACITY: cfg_r.output_capacity <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SOURCE_WIDTH:    prdata = {16'd0, cfg_r.source_width};
      REG_SOURCE_HEIGHT:   prdata = {16'd0, cfg_r.source_height};
      REG_CELLS_PER_ROW:   prdata = {26'd0, cfg_r.cells_per_row};
      REG_OUTPUT_CAPACITY: prdata = {16'd0, cfg_r.output_capacity};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/pgcs_front.sv
`include "assert_macros.svh"

module pgcs_front
  import pgcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  pgcs_in_if.sink   in_chan,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  logic      cmd_pop
);

  cmd_t                q_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wp_r;
  logic [CQ_PTR_W-1:0] rp_r;
  logic [CQ_CNT_W-1:0] q_cnt_r;
  logic                in_acc;
  logic                push;
  logic                pop;
  cmd_t                cmd_in;

  assign in_chan.ready = (q_cnt_r != CQ_CNT_W'(CQ_DEPTH));
  assign in_acc        = in_chan.valid && in_chan.ready;
  // Unused operation codes are dropped here and never reach the back part.
  assign push          = in_acc && (in_chan.operation != OP_NOP);
  assign pop           = cmd_pop && cmd_valid;

  assign cmd_in.kind = op_t'(in_chan.operation);
  assign cmd_in.data = in_chan.packed_byte;

  assign cmd_valid = (q_cnt_r != '0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      q_cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + 1'b1;
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cmd_in;
  end

  `ASSERT_NEXT(a_queue_grows, clk, rst_n, push && !pop, q_cnt_r == $past(q_cnt_r) + 2'd1)

endmodule

// File: rtl/pgcs_div.sv
module pgcs_div
  import pgcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [NUM_W-1:0] quo_r;
  logic [NUM_W-1:0] quo_nxt;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of quo_r at the top while quotient bits enter at the bottom.
  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_dif = rem_sh - {1'b0, den_r};
    rem_nxt = ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// File: rtl/pgcs_back.sv
`include "assert_macros.svh"

module pgcs_back
  import pgcs_pkg::*;
#(
  parameter int STORE_BYTES = 8192,
  parameter int MAX_CELLS   = 62
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  pgcs_out_if.source out_chan
);

  localparam int AW   = $clog2(STORE_BYTES);
  localparam int BL_W = $clog2(STORE_BYTES + 1);
  localparam int SX_W = 22;

  typedef struct packed {
    logic       cmd_pop;
    logic       do_load;
    logic       do_restart;
    logic       prod_en;
    logic       div_start;
    logic       div_w;
    logic       sy_en;
    logic       base_en;
    logic       xinit;
    logic       issue;
    logic       row_end;
    logic       push_seq;
    out_item_t  push_item;
    logic       set_fin;
  } ctl_t;

  seq_state_t state_r, state_nxt;
  ctl_t       ctl;

  // Image progress.
  logic [BL_W-1:0] bl_r;
  logic [15:0]     nr_r;
  logic [15:0]     ch_r;
  logic            fin_r;

  // Row setup.
  logic [32:0]       prod_r;
  logic [21:0]       hct_r;
  logic [15:0]       sy_r;
  logic [31:0]       base_r;
  logic [15:0]       qw_r;
  logic [DEN_W-1:0]  rw_r;
  logic [SX_W-1:0]   sx_r;
  logic [DEN_W-1:0]  xr_r;
  logic [CELL_W-1:0] tx_r;

  // Pixel read in flight.
  logic       pend_r;
  logic       pend_odd_r;
  logic       pend_hit_r;
  logic [7:0] rd_r;
  logic [7:0] mem [STORE_BYTES];

  // Result queue.
  out_item_t           oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wp_r;
  logic [OQ_PTR_W-1:0] rp_r;
  logic [OQ_CNT_W-1:0] cnt_r;

  logic [CELL_W-1:0] tw;
  logic [15:0]       limit;
  logic [16:0]       w2;
  logic              row_ok;
  logic              more;
  logic              room_g;
  logic              room_s;
  logic [31:0]       pix;
  logic              hit;
  logic [DEN_W:0]    xs;
  logic              xcarry;
  logic [3:0]        gray;
  out_item_t         glyph_item;
  logic              push;
  out_item_t         push_item;
  logic              pop;

  logic             div_done;
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] div_quot;
  logic [DEN_W-1:0] div_rem;

  pgcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (div_num),
    .den   (tw),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  assign div_num = ctl.div_w ? {17'd0, cfg.source_width} : prod_r;

  always_comb begin
    tw = (cfg.cells_per_row > CELL_W'(MAX_CELLS)) ? CELL_W'(MAX_CELLS) : cfg.cells_per_row;
    limit = (cfg.output_capacity >= 16'd2) ? cfg.output_capacity - 16'd2 : 16'd0;
    w2 = {cfg.source_width, 1'b0};
    // Another row exists when w, tw != 0, (next_row + 1) * 2w <= h * tw and ch_r < limit.
    row_ok = (cfg.source_width != 16'd0) && (tw != '0) &&
             (({1'b0, prod_r} + {17'd0, w2}) <= {12'd0, hct_r}) && (ch_r < limit);
    more   = (tx_r < tw) && (ch_r < limit);
    room_g = ({1'b0, cnt_r} + {{OQ_CNT_W{1'b0}}, pend_r}) < (OQ_CNT_W + 1)'(OQ_DEPTH);
    room_s = (cnt_r < OQ_CNT_W'(OQ_DEPTH));
    pix    = base_r + {{(32 - SX_W){1'b0}}, sx_r};
    hit    = ({1'b0, pix[31:1]} < 32'(bl_r));
    xs     = {1'b0, xr_r} + {1'b0, rw_r};
    xcarry = (xs >= {1'b0, tw});
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && (cmd.kind == OP_RENDER) && !fin_r) state_nxt = ST_PROD;
      end
      ST_PROD:      state_nxt = ST_DECIDE;
      ST_DECIDE:    state_nxt = row_ok ? ST_SY_DIV : ST_NUL;
      ST_SY_DIV:    if (div_done) state_nxt = ST_BASE;
      ST_BASE:      state_nxt = ST_XDIV;
      ST_XDIV:      if (div_done) state_nxt = ST_CHARS;
      ST_CHARS:     if (!more && !pend_r) state_nxt = ST_ROW_END;
      ST_ROW_END:   state_nxt = ST_POST_PROD;
      ST_POST_PROD: state_nxt = ST_POST_CHK;
      ST_POST_CHK:  if (room_s) state_nxt = row_ok ? ST_IDLE : ST_NUL;
      ST_NUL:       if (room_s) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer strobes.
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.cmd_pop    = cmd_valid;
        ctl.do_load    = cmd_valid && (cmd.kind == OP_LOAD) && (bl_r < BL_W'(STORE_BYTES));
        ctl.do_restart = cmd_valid && (cmd.kind == OP_RESTART);
      end
      ST_PROD, ST_POST_PROD: ctl.prod_en = 1'b1;
      ST_DECIDE: ctl.div_start = row_ok;
      ST_SY_DIV: ctl.sy_en = div_done;
      ST_BASE: begin
        ctl.base_en   = 1'b1;
        ctl.div_start = 1'b1;
        ctl.div_w     = 1'b1;
      end
      ST_XDIV:    ctl.xinit = div_done;
      ST_CHARS:   ctl.issue = more && room_g;
      ST_ROW_END: ctl.row_end = 1'b1;
      ST_POST_CHK: begin
        ctl.push_seq                 = room_s;
        ctl.push_item.char_code      = CODE_NEWLINE;
        ctl.push_item.last           = row_ok;
        ctl.push_item.image_done     = 1'b0;
      end
      ST_NUL: begin
        ctl.push_seq                 = room_s;
        ctl.push_item.char_code      = CODE_NUL;
        ctl.push_item.last           = 1'b1;
        ctl.push_item.image_done     = 1'b1;
        ctl.set_fin                  = room_s;
      end
      default: ;
    endcase
  end

  assign cmd_pop = ctl.cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bl_r    <= '0;
      nr_r    <= '0;
      ch_r    <= '0;
      fin_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= ctl.issue;
      if (ctl.do_restart) begin
        bl_r  <= '0;
        nr_r  <= '0;
        ch_r  <= '0;
        fin_r <= 1'b0;
      end
      if (ctl.do_load) bl_r <= bl_r + 1'b1;
      if (ctl.issue) ch_r <= ch_r + 16'd1;
      if (ctl.row_end) begin
        nr_r <= nr_r + 16'd1;
        ch_r <= ch_r + 16'd1;
      end
      if (ctl.set_fin) fin_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= {17'd0, nr_r} * {16'd0, w2};
      hct_r  <= {6'd0, cfg.source_height} * {16'd0, tw};
    end
    if (ctl.sy_en) begin
      sy_r <= (div_quot >= {17'd0, cfg.source_height}) ? cfg.source_height - 16'd1
                                                       : div_quot[15:0];
    end
    if (ctl.base_en) base_r <= {16'd0, sy_r} * {16'd0, cfg.source_width};
    if (ctl.xinit) begin
      qw_r <= div_quot[15:0];
      rw_r <= div_rem;
      sx_r <= '0;
      xr_r <= '0;
      tx_r <= '0;
    end
    // Column position steps by w/tw with a running remainder.
    if (ctl.issue) begin
      pend_odd_r <= pix[0];
      pend_hit_r <= hit;
      tx_r       <= tx_r + 1'b1;
      xr_r       <= xcarry ? xs[DEN_W-1:0] - tw : xs[DEN_W-1:0];
      sx_r       <= sx_r + {{(SX_W - 16){1'b0}}, qw_r} + {{(SX_W - 1){1'b0}}, xcarry};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_load) mem[bl_r[AW-1:0]] <= cmd.data;
    rd_r <= mem[pix[AW:1]];
  end

  // A byte beyond the loaded count reads as gray zero.
  always_comb begin
    gray = pend_hit_r ? (pend_odd_r ? rd_r[3:0] : rd_r[7:4]) : 4'd0;
    glyph_item.char_code  = gray_glyph(gray);
    glyph_item.last       = 1'b0;
    glyph_item.image_done = 1'b0;
  end

  assign push      = pend_r || ctl.push_seq;
  assign push_item = pend_r ? glyph_item : ctl.push_item;
  assign pop       = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) oq_r[wp_r] <= push_item;
  end

  assign out_chan.valid      = (cnt_r != '0);
  assign out_chan.char_code  = oq_r[rp_r].char_code;
  assign out_chan.last       = oq_r[rp_r].last;
  assign out_chan.image_done = oq_r[rp_r].image_done;

  `ASSERT_IMPLY(a_queue_room, clk, rst_n, pend_r, {1'b0, cnt_r} <= (OQ_CNT_W + 1)'(OQ_DEPTH))
  `ASSERT_IMPLY(a_push_excl, clk, rst_n, ctl.push_seq, !pend_r)
  `ASSERT_NEXT(a_fin_hold, clk, rst_n, fin_r && !ctl.do_restart, fin_r)

endmodule

// File: rtl/packed_gray_to_char_cell_scaler.sv
// Port       Role    Handshake          Contents
// in_chan    sink    valid/ready        operation[1:0], packed_byte[7:0]
// out_chan   source  valid/ready        char_code[6:0], last, image_done
// APB        slave   psel/penable       four registers at byte addresses 0, 4, 8, 12
//
// A load or restart request is taken in the idle state of the back part. A render
// request with a row left runs two 33-step divisions on the serial divider, then
// reads one character per cycle from the pixel store while the result queue has room.
// Reset is synchronous and active low; the pixel store is not cleared.
// A two-entry request queue and a four-entry result queue let either side stall.
module packed_gray_to_char_cell_scaler
  import pgcs_pkg::*;
#(
  parameter int STORE_BYTES = 8192,
  parameter int MAX_CELLS   = 62
) (
  input  logic               clk,
  input  logic               rst_n,
  pgcs_in_if.sink            in_chan,
  pgcs_out_if.source         out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  pgcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pgcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  pgcs_back #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_CELLS   (MAX_CELLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_chan  (out_chan)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

import pgcs_pkg::*;

class char_row_scoreboard;
  localparam int STORE_BYTES = 8192;
  localparam int MAX_CELLS   = 62;

  logic [7:0]  gray_store [STORE_BYTES];
  int unsigned bytes_loaded;
  int unsigned next_row;
  int unsigned chars_emitted;
  bit          finished;

  logic [15:0] width_px;
  logic [15:0] height_px;
  logic [5:0]  cells;
  logic [15:0] capacity;

  out_item_t   expected_chars[$];
  string       ramp;

  int unsigned errors;
  int unsigned n_requests;
  int unsigned n_renders;
  int unsigned n_images;
  int unsigned n_results;

  function new();
    ramp          = " .:-=+*#%@";
    width_px      = RST_SOURCE_WIDTH;
    height_px     = RST_SOURCE_HEIGHT;
    cells         = RST_CELLS_PER_ROW;
    capacity      = RST_OUTPUT_CAPACITY;
    bytes_loaded  = 0;
    next_row      = 0;
    chars_emitted = 0;
    finished      = 1'b0;
    errors        = 0;
    n_requests    = 0;
    n_renders     = 0;
    n_images      = 0;
    n_results     = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      REG_SOURCE_WIDTH:    width_px  = value[15:0];
      REG_SOURCE_HEIGHT:   height_px = value[15:0];
      REG_CELLS_PER_ROW:   cells     = value[5:0];
      REG_OUTPUT_CAPACITY: capacity  = value[15:0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return expected_chars.size();
  endfunction

  // Works out the characters that one accepted request produces.
  function void note_request(op_t op, logic [7:0] data);
    longint unsigned w, h, tw, rows, lim, sy, sx, pix, bi, tx;
    int unsigned     gray;
    logic [6:0]      codes[$];
    bit              dones[$];
    out_item_t       item;

    if (op != OP_NOP) n_requests++;
    case (op)
      OP_LOAD: begin
        if (bytes_loaded < STORE_BYTES) begin
          gray_store[bytes_loaded] = data;
          bytes_loaded++;
        end
      end
      OP_RESTART: begin
        bytes_loaded  = 0;
        next_row      = 0;
        chars_emitted = 0;
        finished      = 1'b0;
      end
      OP_RENDER: begin
        n_renders++;
        if (finished) return;
        w    = width_px;
        h    = height_px;
        tw   = (cells > MAX_CELLS) ? MAX_CELLS : cells;
        lim  = (capacity >= 2) ? capacity - 2 : 0;
        rows = (w == 0 || tw == 0) ? 0 : (h * tw) / (2 * w);
        if (next_row < rows && chars_emitted < lim) begin
          sy = (longint'(next_row) * 2 * w) / tw;
          if (sy >= h) sy = h - 1;
          for (tx = 0; tx < tw && chars_emitted < lim; tx++) begin
            sx   = (tx * w) / tw;
            pix  = sy * w + sx;
            bi   = pix >> 1;
            gray = 0;
            // Pixels past the loaded bytes read as black.
            if (bi < bytes_loaded)
              gray = pix[0] ? gray_store[bi][3:0] : gray_store[bi][7:4];
            codes.push_back(7'(ramp.getc((gray * 9) / 15)));
            dones.push_back(1'b0);
            chars_emitted++;
          end
          codes.push_back(CODE_NEWLINE);
          dones.push_back(1'b0);
          chars_emitted++;
          next_row++;
        end
        if (!(next_row < rows && chars_emitted < lim)) begin
          codes.push_back(CODE_NUL);
          dones.push_back(1'b1);
          finished = 1'b1;
          n_images++;
        end
        foreach (codes[i]) begin
          item.char_code  = codes[i];
          item.last       = (i == codes.size() - 1);
          item.image_done = dones[i];
          expected_chars.push_back(item);
        end
      end
      default: ;
    endcase
  endfunction

  function void check_char(out_item_t got);
    out_item_t want;
    n_results++;
    if (expected_chars.size() == 0) begin
      $error("character %0d arrived with nothing expected", got.char_code);
      errors++;
      return;
    end
    want = expected_chars.pop_front();
    if (got.char_code !== want.char_code) begin
      $error("char_code: expected %0d, got %0d", want.char_code, got.char_code);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      errors++;
    end
    if (got.image_done !== want.image_done) begin
      $error("image_done: expected %0d, got %0d", want.image_done, got.image_done);
      errors++;
    end
  endfunction

  function void close();
    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          SETTLE      = 200;
  localparam int          FILL_BYTES  = 32;
  localparam int unsigned RANDOM_REQS = 100;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  bit                 steady;
  int unsigned        cycles;
  int unsigned        n_settings;

  char_row_scoreboard sb = new();

  pgcs_in_if  in_chan ();
  pgcs_out_if out_chan ();

  packed_gray_to_char_cell_scaler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= steady || ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_char(out_item_t'{out_chan.char_code, out_chan.last, out_chan.image_done});
  end

  task automatic send_req(op_t op, logic [7:0] data);
    int unsigned gap;
    gap = 0;
    if (!steady)
      while ($urandom_range(0, 99) < 31) gap++;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.operation   <= op;
    in_chan.packed_byte <= data;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(op, data);
  endtask

  // Loads and restarts leave no trace on the output, so the block gets extra
  // time after the last character before anything touches the registers.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned tw,
                              int unsigned cap);
    wait_idle();
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_CELLS_PER_ROW, tw);
    write_reg(REG_OUTPUT_CAPACITY, cap);
    n_settings++;
  endtask

  task automatic render_until_done(int unsigned max_renders);
    int unsigned n;
    n = 0;
    while (!sb.finished && n < max_renders) begin
      send_req(OP_RENDER, 8'($urandom));
      n++;
    end
  endtask

  task automatic random_session();
    int unsigned w, h, tw, cap, hmax, nbytes, nload, nrend, kind, pick;
    logic [1:0]  idx;
    logic [31:0] value;

    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      w  = 65535;
      h  = $urandom_range(0, 65535);
      tw = $urandom_range(1, 63);
    end else begin
      w    = $urandom_range(1, 16);
      tw   = (kind == 1) ? $urandom_range(62, 63) : $urandom_range(1, 63);
      hmax = (18 * w) / tw;
      if (hmax < 1) hmax = 1;
      if (hmax > 40) hmax = 40;
      h = $urandom_range(0, hmax);
    end
    pick = $urandom_range(0, 5);
    case (pick)
      0:       cap = $urandom_range(2, 4);
      1:       cap = $urandom_range(5, 40);
      2:       cap = $urandom_range(41, 400);
      default: cap = 65535;
    endcase
    set_geometry(w, h, tw, cap);

    send_req(OP_RESTART, 8'($urandom));
    nbytes = (w * h + 1) / 2;
    nload  = (nbytes > 48 || kind == 0) ? $urandom_range(8, 48) : nbytes;
    if ($urandom_range(0, 3) == 0) nload = $urandom_range(0, nload);
    for (int i = 0; i < nload; i++) begin
      if ($urandom_range(0, 19) == 0) send_req(OP_NOP, 8'($urandom));
      // Now and then the image is thrown away partway through loading.
      if ($urandom_range(0, 59) == 0) send_req(OP_RESTART, 8'($urandom));
      send_req(OP_LOAD, 8'($urandom));
    end

    nrend = 0;
    while (!sb.finished && nrend < 40) begin
      if (nrend == 2 && $urandom_range(0, 4) == 0) begin
        wait_idle();
        idx = 2'($urandom_range(0, 3));
        case (idx)
          REG_SOURCE_WIDTH:  value = $urandom_range(0, 16);
          REG_SOURCE_HEIGHT: value = $urandom_range(0, 40);
          REG_CELLS_PER_ROW: value = $urandom_range(0, 63);
          default:           value = $urandom_range(0, 400);
        endcase
        write_reg(idx, value);
        n_settings++;
      end
      if ($urandom_range(0, 19) == 0) send_req(OP_NOP, 8'($urandom));
      send_req(OP_RENDER, 8'($urandom));
      nrend++;
    end
    if ($urandom_range(0, 1) == 0) send_req(OP_RENDER, 8'($urandom));
  endtask

  initial begin
    logic [7:0]  ramp_bytes[8];
    int unsigned base;

    ramp_bytes = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
    n_settings          <= 0;
    steady              <= 1'b0;
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_chan.valid       <= 1'b0;
    in_chan.operation   <= OP_NOP;
    in_chan.packed_byte <= 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry has no rows: a lone NUL, then nothing after the finish.
    send_req(OP_RENDER, 8'h00);
    send_req(OP_RENDER, 8'h00);
    send_req(OP_NOP, 8'hFF);

    // Every gray level, each sampled twice across a two-row picture.
    set_geometry(8, 2, 16, 65535);
    send_req(OP_RESTART, 8'h00);
    foreach (ramp_bytes[i]) send_req(OP_LOAD, ramp_bytes[i]);
    send_req(OP_RENDER, 8'h00);
    send_req(OP_RENDER, 8'h00);
    send_req(OP_RENDER, 8'h00);

    // Row cut short by the character limit, with most bytes never loaded.
    set_geometry(8, 2, 16, 5);
    send_req(OP_RESTART, 8'h00);
    send_req(OP_LOAD, 8'h00);
    send_req(OP_LOAD, 8'hFF);
    send_req(OP_RENDER, 8'h00);

    // Limit of zero characters, zero cells and zero width all close at once.
    set_geometry(8, 2, 16, 2);
    send_req(OP_RESTART, 8'h00);
    send_req(OP_RENDER, 8'h00);
    set_geometry(8, 2, 16, 1);
    send_req(OP_RESTART, 8'h00);
    send_req(OP_RENDER, 8'h00);
    set_geometry(8, 2, 0, 65535);
    send_req(OP_RESTART, 8'h00);
    send_req(OP_RENDER, 8'h00);
    set_geometry(0, 2, 16, 65535);
    send_req(OP_RESTART, 8'h00);
    send_req(OP_RENDER, 8'h00);

    // Cells above the maximum saturate; the widest image reads mostly black.
    set_geometry(65535, 65535, 63, 65535);
    send_req(OP_RESTART, 8'h00);
    send_req(OP_LOAD, 8'hA5);
    send_req(OP_RENDER, 8'h00);
    send_req(OP_RENDER, 8'h00);

    // Load the first bytes of a large image at full rate and render the whole picture.
    set_geometry(128, 128, 62, 65535);
    send_req(OP_RESTART, 8'h00);
    steady <= 1'b1;
    for (int i = 0; i < FILL_BYTES; i++)
      send_req(OP_LOAD, 8'($urandom));
    render_until_done(40);
    steady <= 1'b0;

    base = sb.n_requests;
    while (sb.n_requests - base < RANDOM_REQS) random_session();

    wait_idle();
    sb.close();
    $display("Covered %0d requests (%0d renders, %0d images closed) over %0d settings.",
             sb.n_requests, sb.n_renders, sb.n_images, n_settings);
    $display("Checked %0d characters, found %0d mismatches.", sb.n_results, sb.errors);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
